### rtl/psrob_pkg.sv
`timescale 1ns / 1ps

package psrob_pkg;

    // Sizing of the reorder store.
    localparam int NUM_SOURCES   = 16;
    localparam int NUM_IDS       = 32;
    localparam int SEQ_DEPTH     = 16;
    localparam int PAYLOAD_WIDTH = 32;

    localparam int NUM_STREAMS = NUM_SOURCES * NUM_IDS;
    localparam int NUM_SLOTS   = NUM_STREAMS * SEQ_DEPTH;

    localparam int SEQ_W    = $clog2(SEQ_DEPTH);
    localparam int STREAM_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
    localparam int SLOT_W   = $clog2(NUM_SLOTS);

    // Fixed field widths of the channels.
    localparam int SRC_FW = 4;
    localparam int TID_FW = 5;
    localparam int SEQ_FW = 4;
    localparam int PL_FW  = 32;

    typedef struct packed {
        logic [SRC_FW-1:0] source_node;
        logic [TID_FW-1:0] txn_id;
        logic [SEQ_FW-1:0] seq;
        logic [PL_FW-1:0]  payload;
    } req_t;

    typedef struct packed {
        logic [PL_FW-1:0]  out_payload;
        logic [SRC_FW-1:0] out_source_node;
        logic [TID_FW-1:0] out_txn_id;
        logic [SEQ_FW-1:0] out_seq;
        logic              last;
    } rel_t;

    // Per-stream state: one occupancy bit per sequence slot and the expected pointer.
    typedef struct packed {
        logic [SEQ_DEPTH-1:0] full;
        logic [SEQ_W-1:0]     expected;
    } row_t;

    // Access request from the sequencer to the stream table.
    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic [STREAM_W-1:0] addr;
        row_t                wdata;
    } row_req_t;

    // Advance a sequence pointer modulo the depth.
    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] ptr);
        logic [SEQ_W-1:0] res;
        if (ptr == SEQ_W'(SEQ_DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = ptr + SEQ_W'(1);
        end
        return res;
    endfunction

    // Flat slot address of one sequence slot of one stream.
    function automatic logic [SLOT_W-1:0] slot_addr(input logic [STREAM_W-1:0] stream,
                                                    input logic [SEQ_W-1:0] sq);
        return SLOT_W'(32'(stream) * SEQ_DEPTH + 32'(sq));
    endfunction

endpackage

### rtl/per_stream_inorder_reorder_buffer_core.sv
`timescale 1ns / 1ps

// Per-stream in-order reorder buffer.
// Request transactions enter on the req channel (req_valid / req_ready) and
// carry source node, transaction id, sequence number and payload. The pair of
// source node and transaction id names a stream. The payload is parked in
// the slot memory at that stream and sequence number; while the slot at the
// stream's expected pointer is full, it is released on the rel channel
// (rel_valid / rel_ready) in sequence order, and the final release caused by
// one request carries last. Requests with an index out of range are taken and
// dropped.
// Timing: a request is taken in the idle state only. It stores its payload,
// reads the stream row (S_RD), merges it (S_ROW) and returns to idle if no
// slot is due; else each release reads its slot into the read register
// (S_EMIT), then loads the output register (S_LOAD), until the run ends.
// Reset: after rst_n rises the stream table is swept clear, one stream per
// cycle; req_ready stays low until the sweep ends. A stall on rel holds the
// output register and the sequencer waits before reading the next slot; no
// release is lost.
module per_stream_inorder_reorder_buffer_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  psrob_pkg::req_t req,
    output logic            rel_valid,
    input  logic            rel_ready,
    output psrob_pkg::rel_t rel
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_ROW,
        S_EMIT,
        S_LOAD
    } state_t;

    state_t                                state_reg;
    logic [psrob_pkg::SRC_FW-1:0]          src_reg;
    logic [psrob_pkg::TID_FW-1:0]          tid_reg;
    logic [psrob_pkg::SEQ_W-1:0]           seq_reg;
    logic [psrob_pkg::PAYLOAD_WIDTH-1:0]   payload_reg;
    logic [psrob_pkg::STREAM_W-1:0]        stream_reg;
    logic [psrob_pkg::SEQ_DEPTH-1:0]       full_reg;
    logic [psrob_pkg::SEQ_W-1:0]           ptr_reg;
    logic                                  rel_valid_reg;
    psrob_pkg::rel_t                       rel_reg;

    logic [psrob_pkg::PAYLOAD_WIDTH-1:0]   slot_mem [psrob_pkg::NUM_SLOTS];
    logic [psrob_pkg::PAYLOAD_WIDTH-1:0]   slot_rdata_reg;

    psrob_pkg::row_req_t                   row_req;
    psrob_pkg::row_t                       row_rdata;
    logic                                  init_done;

    logic                                  req_fire;
    logic                                  in_range;
    logic                                  out_free;
    logic [psrob_pkg::SEQ_DEPTH-1:0]       full_merged;
    logic [psrob_pkg::SEQ_DEPTH-1:0]       full_cleared;
    logic [psrob_pkg::SEQ_W-1:0]           ptr_inc;
    logic                                  run_last;

    psrob_stream_table u_stream_table
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (row_req),
        .rdata     (row_rdata),
        .init_done (init_done)
    );

    // Handshake and per-state helper terms.
    assign req_ready = (state_reg == S_IDLE) && init_done;
    assign req_fire  = req_valid && req_ready;
    assign in_range  = (32'(req.source_node) < psrob_pkg::NUM_SOURCES) &&
                       (32'(req.txn_id) < psrob_pkg::NUM_IDS) &&
                       (32'(req.seq) < psrob_pkg::SEQ_DEPTH);
    assign out_free  = !rel_valid_reg || rel_ready;

    assign full_merged  = row_rdata.full | (psrob_pkg::SEQ_DEPTH'(1) << seq_reg);
    assign full_cleared = full_reg & ~(psrob_pkg::SEQ_DEPTH'(1) << ptr_reg);
    assign ptr_inc      = psrob_pkg::seq_inc(ptr_reg);
    assign run_last     = !full_cleared[ptr_inc];

    // Stream table accesses: read on entry, write back when the run ends.
    always_comb
    begin
        row_req       = '0;
        row_req.addr  = stream_reg;
        case (state_reg)
            S_RD:
            begin
                row_req.rd_en = 1'b1;
            end
            S_ROW:
            begin
                if (!full_merged[row_rdata.expected])
                begin
                    row_req.wr_en          = 1'b1;
                    row_req.wdata.full     = full_merged;
                    row_req.wdata.expected = row_rdata.expected;
                end
            end
            S_LOAD:
            begin
                if (run_last)
                begin
                    row_req.wr_en          = 1'b1;
                    row_req.wdata.full     = full_cleared;
                    row_req.wdata.expected = ptr_inc;
                end
            end
            default:
            begin
                row_req.rd_en = 1'b0;
            end
        endcase
    end

    // Slot memory: store the arriving payload, read the slot being released.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            slot_mem[psrob_pkg::slot_addr(stream_reg, seq_reg)] <= payload_reg;
        end
        if ((state_reg == S_EMIT) && out_free)
        begin
            slot_rdata_reg <= slot_mem[psrob_pkg::slot_addr(stream_reg, ptr_reg)];
        end
    end

    // Captured request fields; no reset needed.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            src_reg     <= req.source_node;
            tid_reg     <= req.txn_id;
            seq_reg     <= psrob_pkg::SEQ_W'(req.seq);
            payload_reg <= psrob_pkg::PAYLOAD_WIDTH'(req.payload);
            stream_reg  <= psrob_pkg::STREAM_W'(32'(req.source_node) * psrob_pkg::NUM_IDS +
                                                32'(req.txn_id));
        end
    end

    // Sequencer with the registered release output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rel_valid_reg <= 1'b0;
            full_reg      <= '0;
            ptr_reg       <= '0;
            rel_reg       <= '0;
        end
        else
        begin
            if (rel_valid_reg && rel_ready)
            begin
                rel_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire && in_range)
                    begin
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_ROW;
                end
                S_ROW:
                begin
                    full_reg <= full_merged;
                    ptr_reg  <= row_rdata.expected;
                    if (full_merged[row_rdata.expected])
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    rel_valid_reg           <= 1'b1;
                    rel_reg.out_payload     <= psrob_pkg::PL_FW'(slot_rdata_reg);
                    rel_reg.out_source_node <= src_reg;
                    rel_reg.out_txn_id      <= tid_reg;
                    rel_reg.out_seq         <= psrob_pkg::SEQ_FW'(ptr_reg);
                    rel_reg.last            <= run_last;
                    full_reg                <= full_cleared;
                    ptr_reg                 <= ptr_inc;
                    if (run_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rel_valid = rel_valid_reg;
    assign rel       = rel_reg;

    // No request is taken before the stream table sweep completes.
    a_no_req_before_init: assert property (@(posedge clk) disable iff (!rst_n)
        !init_done |-> !req_ready)
        else $error("request taken during stream table sweep");

    // A taken request keeps the input closed in the following cycle.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req_ready)
        else $error("second request taken while one is in work");

    // The output register is empty whenever a slot read lands.
    a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> !rel_valid_reg)
        else $error("release would overwrite a pending transaction");

    // The sequencer only reads slots that are marked full.
    a_emit_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> full_reg[ptr_reg])
        else $error("release of an empty slot");

    // A run that is not finished goes on with the next slot read.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_LOAD) && !run_last) |=> (state_reg == S_EMIT))
        else $error("release run stopped early");

endmodule

### rtl/psrob_stream_table.sv
`timescale 1ns / 1ps

module psrob_stream_table
(
    input  logic                clk,
    input  logic                rst_n,
    input  psrob_pkg::row_req_t req,
    output psrob_pkg::row_t     rdata,
    output logic                init_done
);

    psrob_pkg::row_t                     stream_mem [psrob_pkg::NUM_STREAMS];
    psrob_pkg::row_t                     rdata_reg;
    logic [psrob_pkg::STREAM_W-1:0]      clr_cnt_reg;
    logic [psrob_pkg::STREAM_W-1:0]      clr_cnt_next;
    logic                                init_done_reg;
    logic                                init_done_next;
    logic                                mem_we;
    logic [psrob_pkg::STREAM_W-1:0]      mem_waddr;
    psrob_pkg::row_t                     mem_wdata;

    // Clearing sweep after reset, one row per cycle.
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        init_done_next = init_done_reg;
        if (!init_done_reg)
        begin
            if (clr_cnt_reg == psrob_pkg::STREAM_W'(psrob_pkg::NUM_STREAMS - 1))
            begin
                init_done_next = 1'b1;
            end
            else
            begin
                clr_cnt_next = clr_cnt_reg + psrob_pkg::STREAM_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            init_done_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg   <= clr_cnt_next;
            init_done_reg <= init_done_next;
        end
    end

    // The sweep owns the write port until it finishes.
    always_comb
    begin
        if (!init_done_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = req.wr_en;
            mem_waddr = req.addr;
            mem_wdata = req.wdata;
        end
    end

    // Synchronous memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stream_mem[mem_waddr] <= mem_wdata;
        end
        if (req.rd_en)
        begin
            rdata_reg <= stream_mem[req.addr];
        end
    end

    assign rdata     = rdata_reg;
    assign init_done = init_done_reg;

endmodule

### tb/per_stream_inorder_reorder_buffer_core_test.sv
`timescale 1ns / 1ps

module per_stream_inorder_reorder_buffer_core_test;

    localparam int unsigned TOTAL_ITEMS    = 400;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam logic [63:0] PL_MASK        = (64'd1 << psrob_pkg::PAYLOAD_WIDTH) - 64'd1;

    // Tracks the slot store of every stream and the releases that are due.
    class release_tracker;
        logic [psrob_pkg::PL_FW-1:0] slot_data [psrob_pkg::NUM_SLOTS];
        bit                          slot_busy [psrob_pkg::NUM_SLOTS];
        int unsigned                 next_seq [psrob_pkg::NUM_STREAMS];
        psrob_pkg::rel_t             due_releases [$];
        int unsigned                 errors;

        function new();
            foreach (slot_busy[i])
            begin
                slot_busy[i] = 1'b0;
            end
            foreach (next_seq[i])
            begin
                next_seq[i] = 0;
            end
            errors = 0;
        endfunction

        // Pointer of one stream, zero for a stream that does not exist.
        function int unsigned stream_ptr(int unsigned src, int unsigned tid);
            if (src >= psrob_pkg::NUM_SOURCES || tid >= psrob_pkg::NUM_IDS)
            begin
                return 0;
            end
            return next_seq[src * psrob_pkg::NUM_IDS + tid];
        endfunction

        // Store an accepted request and queue every release it unblocks.
        function void take_request(psrob_pkg::req_t r);
            int unsigned     s;
            int unsigned     base;
            int unsigned     ptr;
            int unsigned     n;
            int unsigned     cnt;
            psrob_pkg::rel_t item;
            if (r.source_node >= psrob_pkg::NUM_SOURCES || r.txn_id >= psrob_pkg::NUM_IDS ||
                r.seq >= psrob_pkg::SEQ_DEPTH)
            begin
                return;
            end
            s    = r.source_node * psrob_pkg::NUM_IDS + r.txn_id;
            base = s * psrob_pkg::SEQ_DEPTH;
            slot_data[base + r.seq] = psrob_pkg::PL_FW'(64'(r.payload) & PL_MASK);
            slot_busy[base + r.seq] = 1'b1;
            cnt = 0;
            for (n = 0; n < psrob_pkg::SEQ_DEPTH; n++)
            begin
                ptr = next_seq[s];
                if (!slot_busy[base + ptr])
                begin
                    break;
                end
                item.out_payload     = slot_data[base + ptr];
                item.out_source_node = r.source_node;
                item.out_txn_id      = r.txn_id;
                item.out_seq         = psrob_pkg::SEQ_FW'(ptr);
                item.last            = 1'b0;
                due_releases.insert(due_releases.size(), item);
                slot_busy[base + ptr] = 1'b0;
                next_seq[s] = (ptr + 1) % psrob_pkg::SEQ_DEPTH;
                cnt++;
            end
            // The final release of this request carries last.
            if (cnt > 0)
            begin
                due_releases[due_releases.size() - 1].last = 1'b1;
            end
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v)
            begin
                $display("%0t: release %s mismatch: expected %0h, actual %0h",
                         $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Compare one accepted release with the oldest one due.
        function void check_release(psrob_pkg::rel_t got);
            psrob_pkg::rel_t want;
            if (due_releases.size() == 0)
            begin
                $display("%0t: unexpected release: expected none, actual %0h", $time, got);
                errors++;
                return;
            end
            want = due_releases[0];
            due_releases.delete(0);
            compare_field("out_payload", 64'(want.out_payload), 64'(got.out_payload));
            compare_field("out_source_node", 64'(want.out_source_node),
                          64'(got.out_source_node));
            compare_field("out_txn_id", 64'(want.out_txn_id), 64'(got.out_txn_id));
            compare_field("out_seq", 64'(want.out_seq), 64'(got.out_seq));
            compare_field("last", 64'(want.last), 64'(got.last));
        endfunction

        function int unsigned pending();
            return due_releases.size();
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_ready;
    psrob_pkg::req_t req;
    logic            rel_valid;
    logic            rel_ready;
    psrob_pkg::rel_t rel;

    release_tracker tracker;
    int unsigned    accepted;
    int unsigned    phase_idx;

    per_stream_inorder_reorder_buffer_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rel_valid (rel_valid),
        .rel_ready (rel_ready),
        .rel       (rel)
    );

    // Clock generation.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Idle rates per phase: receiver slow first, then sender slow, then no idling.
    function automatic int unsigned send_idle_pct();
        case (phase_idx)
            0: return 27;
            1: return 66;
            default: return 0;
        endcase
    endfunction

    function automatic int unsigned recv_idle_pct();
        case (phase_idx)
            0: return 66;
            1: return 27;
            default: return 0;
        endcase
    endfunction

    // Release channel: check each accepted transaction, then pick the next ready.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rel_valid && rel_ready)
            begin
                tracker.check_release(rel);
            end
            rel_ready <= ($urandom_range(99) >= recv_idle_pct());
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rel_valid && rel_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("per_stream_inorder_reorder_buffer_core_test: done, errors");
        $finish;
    end

    // Offer one request transaction, wait for it to be taken, then maybe idle.
    task automatic send_req(input psrob_pkg::req_t r);
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
        begin
            @(posedge clk);
        end
        tracker.take_request(r);
        accepted++;
        phase_idx = (accepted * 3) / TOTAL_ITEMS;
        if ($urandom_range(99) < send_idle_pct())
        begin
            req_valid <= 1'b0;
            do
            begin
                @(posedge clk);
            end
            while ($urandom_range(99) < send_idle_pct());
        end
    endtask

    task automatic send_fields(input int unsigned src, input int unsigned tid,
                               input int unsigned sq, input logic [psrob_pkg::PL_FW-1:0] pl);
        psrob_pkg::req_t r;
        r.source_node = psrob_pkg::SRC_FW'(src);
        r.txn_id      = psrob_pkg::TID_FW'(tid);
        r.seq         = psrob_pkg::SEQ_FW'(sq);
        r.payload     = pl;
        send_req(r);
    endtask

    // Directed cases: field extremes, out-of-order runs, overwrite and wrap.
    task automatic run_directed();
        int i;
        // In-order arrival releases at once.
        send_fields(0, 0, 0, '0);
        // Top stream: a stray entry at the top sequence, then a run of three.
        send_fields(15, 31, 15, '1);
        send_fields(15, 31, 2, 32'h5555_5555);
        send_fields(15, 31, 1, 32'hAAAA_AAAA);
        send_fields(15, 31, 0, 32'h0000_0001);
        // A full slot is overwritten by a second arrival.
        send_fields(3, 7, 1, 32'h1111_1111);
        send_fields(3, 7, 1, 32'h2222_2222);
        send_fields(3, 7, 0, 32'h8000_0000);
        // Fill a whole stream backwards so one request releases all slots,
        // then show that the pointer wrapped back to zero.
        for (i = psrob_pkg::SEQ_DEPTH - 1; i >= 1; i--)
        begin
            send_fields(1, 1, i, $urandom);
        end
        send_fields(1, 1, 0, $urandom);
        send_fields(1, 1, 0, 32'hFFFF_0000);
    endtask

    // Random part: mostly shuffled windows at a stream's pointer, plus noise.
    task automatic run_random();
        int unsigned pool_src [6];
        int unsigned pool_tid [6];
        int unsigned order [psrob_pkg::SEQ_DEPTH];
        int unsigned src;
        int unsigned tid;
        int unsigned ptr;
        int unsigned span;
        int unsigned skip;
        int unsigned pick;
        int unsigned tmp;
        int unsigned i;
        foreach (pool_src[k])
        begin
            pool_src[k] = $urandom_range((1 << psrob_pkg::SRC_FW) - 1);
            pool_tid[k] = $urandom_range((1 << psrob_pkg::TID_FW) - 1);
        end
        while (accepted < TOTAL_ITEMS)
        begin
            if ($urandom_range(99) < 15)
            begin
                // Noise: any stream, any sequence.
                send_fields($urandom_range((1 << psrob_pkg::SRC_FW) - 1),
                            $urandom_range((1 << psrob_pkg::TID_FW) - 1),
                            $urandom_range((1 << psrob_pkg::SEQ_FW) - 1), $urandom);
            end
            else
            begin
                if ($urandom_range(99) < 60)
                begin
                    pick = $urandom_range(5);
                    src  = pool_src[pick];
                    tid  = pool_tid[pick];
                end
                else
                begin
                    src = $urandom_range((1 << psrob_pkg::SRC_FW) - 1);
                    tid = $urandom_range((1 << psrob_pkg::TID_FW) - 1);
                end
                ptr  = tracker.stream_ptr(src, tid);
                span = ($urandom_range(3) == 0) ? $urandom_range(psrob_pkg::SEQ_DEPTH, 7)
                                                : $urandom_range(6, 1);
                for (i = 0; i < span; i++)
                begin
                    order[i] = i;
                end
                for (i = span - 1; i > 0; i--)
                begin
                    pick     = $urandom_range(i);
                    tmp      = order[i];
                    order[i] = order[pick];
                    order[pick] = tmp;
                end
                // Now and then one message of the window goes missing.
                skip = ($urandom_range(9) == 0) ? $urandom_range(span - 1)
                                                : psrob_pkg::SEQ_DEPTH;
                for (i = 0; i < span; i++)
                begin
                    if (i != skip)
                    begin
                        if ($urandom_range(99) < 8)
                        begin
                            send_fields(src, tid, (ptr + order[i]) % psrob_pkg::SEQ_DEPTH,
                                        $urandom);
                        end
                        send_fields(src, tid, (ptr + order[i]) % psrob_pkg::SEQ_DEPTH,
                                    $urandom);
                    end
                end
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        tracker   = new();
        accepted  = 0;
        phase_idx = 0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        rel_ready = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        req_valid <= 1'b0;
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
        begin
            $display("per_stream_inorder_reorder_buffer_core_test: done, clean");
        end
        else
        begin
            $display("per_stream_inorder_reorder_buffer_core_test: done, errors");
        end
        $finish;
    end

endmodule
